### rtl/cewh_pkg.sv
// ----------------------------------------------------------------------------
// cewh_pkg
// Shared types and constants for the coincidence energy window histogrammer.
// ----------------------------------------------------------------------------
package cewh_pkg;

  localparam int unsigned BINS        = 8192;
  localparam int unsigned COUNT_WIDTH = 32;
  localparam int unsigned BIN_W       = $clog2(BINS);
  localparam int unsigned ADDR_W      = BIN_W + 2;
  localparam int unsigned DEPTH       = 4 * BINS;
  localparam int unsigned CFG_W       = 48;
  localparam int unsigned E_W         = 36;
  localparam int unsigned LANES       = 3;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [2:0] {
    REG_CAL0   = 3'd0,
    REG_CAL1   = 3'd1,
    REG_CAL2   = 3'd2,
    REG_CENTER = 3'd3,
    REG_WIDTH  = 3'd4,
    REG_NSUM   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic         mode;
    logic [63:0]  time_a;
    logic [63:0]  time_b;
    logic [63:0]  time_c;
    logic [63:0]  time_d;
    logic [15:0]  charge_a;
    logic [15:0]  charge_b;
    logic [15:0]  charge_c;
    logic [15:0]  charge_d;
    logic [1:0]   read_channel;
    logic [12:0]  read_bin;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         advance_mask;
    logic               coincident;
    logic               in_window;
    logic               not_calibrated;
    logic signed [35:0] energy_total;
    logic [15:0]        tac_max;
    logic [31:0]        bin_count;
  } out_item_t;

  function automatic logic [BIN_W-1:0] bin_of(input logic [15:0] q);
    logic [16+BIN_W-1:0] p;
    p = {{BIN_W{1'b0}}, q} * (16+BIN_W)'(BINS);
    return p[16+BIN_W-1:16];
  endfunction

endpackage

### rtl/cewh_if.sv
// ----------------------------------------------------------------------------
// cewh_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface cewh_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/coincidence_energy_window_histogrammer.sv
// ----------------------------------------------------------------------------
// coincidence_energy_window_histogrammer
// Four-channel timestamp coincidence with summed-energy window and histograms.
// ----------------------------------------------------------------------------
// Channel  Dir  Beat
// in_ch    in   event heads or bin read request (in_item_t)
// out_ch   out  one result per input beat (out_item_t)
// cfg      in   we / idx / wdata register writes
//
// Four pipeline stages: compare and multiply; lane sum, window test and RAM
// read; counter update with forwarding; output register. One beat per cycle
// unless stalled or clearing; a result passes the v1, v2 and v3 registers.
// Histogram counters are zeroed by a clearing pass over all 8192 bins after
// reset, during which no beat is accepted. The pipeline advances only when
// the output register is free or being taken.
module coincidence_energy_window_histogrammer (
  input  logic        clk,
  input  logic        rst,
  cewh_if.sink        in_ch,
  cewh_if.source      out_ch,
  input  logic        we,
  input  logic [2:0]  idx,
  input  logic [47:0] wdata
);
  import cewh_pkg::*;

  logic [CFG_W-1:0] cal [LANES];
  logic [31:0] center, width;
  logic [1:0]  nsum;
  logic [BIN_W:0] clr_cnt;
  logic clearing;
  assign clearing = !clr_cnt[BIN_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      cal[0] <= '0; cal[1] <= '0; cal[2] <= '0;
      center <= '0; width <= '0; nsum <= 2'd3;
    end else if (we) begin
      case (reg_idx_t'(idx))
        REG_CAL0:   cal[0] <= wdata;
        REG_CAL1:   cal[1] <= wdata;
        REG_CAL2:   cal[2] <= wdata;
        REG_CENTER: center <= wdata[31:0];
        REG_WIDTH:  width  <= wdata[31:0];
        REG_NSUM:   nsum   <= wdata[1:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic v1, v2, v3;
  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv && !clearing;
  logic acc;
  assign acc = in_ch.valid && in_ch.ready;

  // ---- stage 0 combinational
  in_item_t d;
  assign d = in_ch.data;
  logic [1:0] n_eff;
  logic uncal0, coinc0;
  logic [3:0] mask0;
  logic [2:0] use_l;
  always_comb begin
    logic stop;
    n_eff = (nsum == 2'd0) ? 2'd1 : nsum;
    use_l = {n_eff == 2'd3, n_eff >= 2'd2, 1'b1};
    uncal0 = 1'b0;
    for (int i = 0; i < LANES; i++)
      if (use_l[i] && cal[i][47:24] == 24'd0) uncal0 = 1'b1;
    coinc0 = (d.time_a == d.time_b) && (d.time_a == d.time_c) &&
             (d.time_a == d.time_d);
    mask0 = '0;
    stop = 1'b0;
    if (coinc0) mask0 = 4'hf;
    else begin
      if (d.time_a < d.time_b) begin mask0[0] = 1'b1; stop = 1'b1; end
      else if (d.time_a > d.time_b) mask0[1] = 1'b1;
      if (!stop) begin
        if (d.time_a < d.time_c) begin mask0[0] = 1'b1; stop = 1'b1; end
        else if (d.time_a > d.time_c) mask0[2] = 1'b1;
      end
      if (!stop) begin
        if (d.time_a < d.time_d) mask0[0] = 1'b1;
        else if (d.time_a > d.time_d) mask0[3] = 1'b1;
      end
    end
    if (d.mode) begin
      mask0 = '0; uncal0 = 1'b0; coinc0 = 1'b0;
    end
  end

  // A bin read looks up the same bin in every channel; the channel is
  // picked when the result is built.
  logic [ADDR_W-1:0] addr0 [4];
  always_comb begin
    addr0[0] = {2'd0, bin_of(d.charge_a)};
    addr0[1] = {2'd1, bin_of(d.charge_b)};
    addr0[2] = {2'd2, bin_of(d.charge_c)};
    addr0[3] = {2'd3, bin_of(d.charge_d)};
    if (d.mode)
      for (int i = 0; i < 4; i++) addr0[i] = {2'(i), d.read_bin[BIN_W-1:0]};
  end

  logic signed [E_W-1:0] e [LANES];
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    cewh_lane u_lane (
      .clk(clk), .en(adv), .cal(cal[g]),
      .charge(g == 0 ? d.charge_a : (g == 1 ? d.charge_b : d.charge_c)),
      .use_lane(use_l[g]), .energy(e[g])
    );
  end

  // ---- stage 1 registers
  logic        s1_mode, s1_coinc, s1_uncal;
  logic [3:0]  s1_mask;
  logic [15:0] s1_tac;
  logic [ADDR_W-1:0] s1_addr [4];
  logic        s1_rd_ok;
  logic [1:0]  s1_rsel;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= acc;
    if (adv) begin
      s1_mode  <= d.mode;
      s1_coinc <= coinc0;
      s1_uncal <= uncal0;
      s1_mask  <= mask0;
      s1_tac   <= d.charge_d;
      for (int i = 0; i < 4; i++) s1_addr[i] <= addr0[i];
      s1_rd_ok <= 32'(d.read_bin) < BINS;
      s1_rsel  <= d.read_channel;
    end
  end

  // Energy sum and window test at stage 1.
  logic signed [E_W-1:0] esum1;
  logic win1;
  always_comb begin
    logic signed [E_W+1:0] tc, tw, te;
    esum1 = e[0] + e[1] + e[2];
    tc = {5'd0, center, 1'b0};
    tw = {6'd0, width};
    te = {esum1[E_W-1], esum1, 1'b0};
    win1 = s1_coinc && !s1_uncal && (tc - tw < te) && (tc + tw > te);
  end

  // ---- histogram: one RAM per channel, read at stage 1, written at stage 3
  logic [COUNT_WIDTH-1:0] rdat [4];
  logic [COUNT_WIDTH-1:0] wval [4];
  logic [ADDR_W-1:0] s2_addr [4], s3_addr [4];
  logic [COUNT_WIDTH-1:0] s3_val [4];
  logic s3_we, s2_win;
  for (genvar g = 0; g < 4; g++) begin : g_ram
    logic wen;
    logic [BIN_W-1:0] wa;
    assign wen = clearing || s3_we;
    assign wa  = clearing ? clr_cnt[BIN_W-1:0] : s3_addr[g][BIN_W-1:0];
    cewh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(BINS)) u_ram (
      .clk(clk), .we(wen), .waddr(wa),
      .wdata(clearing ? '0 : s3_val[g]),
      .raddr(s1_addr[g][BIN_W-1:0]), .rdata(rdat[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (clearing) clr_cnt <= clr_cnt + (BIN_W+1)'(1);
  end

  // ---- stage 2
  logic        s2_mode, s2_coinc, s2_uncal, s2_rd_ok;
  logic [3:0]  s2_mask;
  logic [15:0] s2_tac;
  logic signed [E_W-1:0] s2_esum;
  logic [1:0]  s2_rsel;
  logic [15:0] largest;
  always_ff @(posedge clk) begin
    if (rst) begin v2 <= 1'b0; largest <= '0; end
    else if (adv) begin
      v2 <= v1;
      if (v1 && s1_coinc && s1_tac > largest) largest <= s1_tac;
    end
    if (adv) begin
      s2_mode <= s1_mode; s2_coinc <= s1_coinc; s2_uncal <= s1_uncal;
      s2_mask <= s1_mask; s2_esum <= s1_coinc ? esum1 : '0;
      s2_win  <= v1 && win1; s2_rd_ok <= s1_rd_ok;
      s2_tac  <= (v1 && s1_coinc && s1_tac > largest) ? s1_tac : largest;
      s2_rsel <= s1_rsel;
      for (int i = 0; i < 4; i++) s2_addr[i] <= s1_addr[i];
    end
  end

  // Fresh read data misses the write committed at the edge it was read and
  // the write still waiting in stage 3, so both are forwarded. During a
  // stall the value seen in the first cycle is held.
  logic [COUNT_WIDTH-1:0] cur [4];
  logic [COUNT_WIDTH-1:0] rhold [4];
  logic s2_fresh;
  logic s4_we;
  logic [ADDR_W-1:0] s4_addr [4];
  logic [COUNT_WIDTH-1:0] s4_val [4];
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_fresh <= 1'b0;
      s4_we    <= 1'b0;
    end else begin
      s2_fresh <= adv;
      s4_we    <= s3_we;
    end
    for (int i = 0; i < 4; i++) begin
      rhold[i]   <= cur[i];
      s4_addr[i] <= s3_addr[i];
      s4_val[i]  <= s3_val[i];
    end
  end
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cur[i] = s2_fresh ? rdat[i] : rhold[i];
      if (s2_fresh && s4_we && s4_addr[i] == s2_addr[i]) cur[i] = s4_val[i];
      if (s3_we && s3_addr[i] == s2_addr[i]) cur[i] = s3_val[i];
      wval[i] = (cur[i] == CNT_MAX) ? cur[i] : cur[i] + COUNT_WIDTH'(1);
    end
  end

  // ---- stage 3: write back and output register
  out_item_t o;
  always_ff @(posedge clk) begin
    if (rst) begin v3 <= 1'b0; s3_we <= 1'b0; end
    else begin
      s3_we <= adv && v2 && s2_win;
      if (adv) v3 <= v2;
    end
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        s3_addr[i] <= s2_addr[i];
        s3_val[i]  <= wval[i];
      end
      o.advance_mask   <= s2_mask;
      o.coincident     <= s2_coinc;
      o.in_window      <= s2_win;
      o.not_calibrated <= s2_uncal;
      o.energy_total   <= s2_esum;
      o.tac_max        <= s2_tac;
      o.bin_count      <= (s2_mode && s2_rd_ok) ? 32'(cur[s2_rsel]) : '0;
    end
  end

  assign out_ch.valid = v3;
  assign out_ch.data  = o;
endmodule

### rtl/cewh_ram.sv
// ----------------------------------------------------------------------------
// cewh_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module cewh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### rtl/cewh_lane.sv
// ----------------------------------------------------------------------------
// cewh_lane
// One calibration lane: registered gain*charge product, then offset add.
// ----------------------------------------------------------------------------
module cewh_lane (
  input  logic                     clk,
  input  logic                     en,
  input  logic [cewh_pkg::CFG_W-1:0] cal,
  input  logic [15:0]              charge,
  input  logic                     use_lane,
  output logic signed [cewh_pkg::E_W-1:0] energy
);
  import cewh_pkg::*;
  logic [39:0]        prod;
  logic signed [23:0] offs;
  logic               use_q;

  // Stage 1 registers the product; stage 2 adds the offset.
  always_ff @(posedge clk) begin
    if (en) begin
      prod  <= 40'(cal[47:24]) * 40'(charge);
      offs  <= cal[23:0];
      use_q <= use_lane;
    end
  end

  always_comb begin
    if (use_q) energy = E_W'($signed({1'b0, prod[39:8]})) + E_W'(offs);
    else       energy = '0;
  end
endmodule
